// ===== rtl/asx_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the ASTERIX SAC/SIC extractor.
// No dependencies.
package asx_pkg;

   localparam int ByteWidth      = 8;
   localparam int CountWidth     = 16;
   localparam int CsrIndexWidth  = 2;
   localparam int CsrDataWidth   = 16;
   localparam int RspTdataWidth  = 24;
   localparam int RspFieldWidth  = 2 * ByteWidth + 1;

   localparam logic [CountWidth-1:0] MinBlockLength = 16'd3;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CsrHeaderSkip = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrPreSkip    = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrPostSkip   = 2'd2;

   // Result status codes
   localparam logic StatusPairFound = 1'b0;
   localparam logic StatusBadLength = 1'b1;

   // FSPEC bits of interest
   localparam int FspecSacSicBit = 7;
   localparam int FspecExtBit    = 0;

   typedef enum logic [7:0] {
      PH_HEADER = 8'b0000_0001,
      PH_PRE    = 8'b0000_0010,
      PH_CAT    = 8'b0000_0100,
      PH_LEN_HI = 8'b0000_1000,
      PH_LEN_LO = 8'b0001_0000,
      PH_BODY   = 8'b0010_0000,
      PH_POST   = 8'b0100_0000,
      PH_HALT   = 8'b1000_0000
   } phase_type;

   typedef enum logic [1:0] {
      POS_FIRST = 2'd0,
      POS_EXT   = 2'd1,
      POS_SAC   = 2'd2,
      POS_SIC   = 2'd3
   } body_pos_type;

endpackage

// ===== rtl/asterix_sac_sic_extractor.sv =====
`timescale 1ns / 1ps
// Top level: frames recorded ASTERIX data blocks and pulls SAC/SIC per block.
// Depends on asx_pkg.
//
//   channel | dir | fields (low bit first)
//   req_    | in  | tdata[7:0] data_byte
//   rsp_    | out | tdata[7:0] source_area, [15:8] source_ident, [16] status
//   csr_    | in  | write_en, index 0..2, wdata 16 bit
//
// One byte per cycle while not stalled; the result registers in the cycle after accept;
// the byte's state update is a single pass of next-state logic on the framing counters.
// Synchronous active-high reset clears framing state: phase to PH_HEADER, other state
// registers to 0; the result payload is not reset. The input stalls only while a result
// waits in the output register and rsp_tready is low; a waiting result does not block accepting a byte otherwise.
module asterix_sac_sic_extractor (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [asx_pkg::ByteWidth-1:0]       req_tdata,    // [7:0] data_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [asx_pkg::RspTdataWidth-1:0]   rsp_tdata,    // area, ident, status
   input  logic                                csr_write_en,
   input  logic [asx_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [asx_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import asx_pkg::*;

   logic [CountWidth-1:0] header_skip_ff, pre_skip_ff, post_skip_ff;

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] skip_count_ff, skip_count_in;
   logic [CountWidth-1:0] remaining_ff, remaining_in;
   logic [ByteWidth-1:0]  length_high_ff, length_high_in;
   body_pos_type          pos_ff, pos_in;
   logic [ByteWidth-1:0]  area_ff, area_in;
   logic [ByteWidth-1:0]  ident_ff, ident_in;
   logic                  pair_valid_ff, pair_valid_in;
   logic                  body_done_ff, body_done_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ByteWidth-1:0]  rsp_area_ff, rsp_area_in;
   logic [ByteWidth-1:0]  rsp_ident_ff, rsp_ident_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  emit;
   logic [ByteWidth-1:0]  b;
   logic [CountWidth-1:0] length;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign length     = {length_high_ff, b};

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff <= '0;
         pre_skip_ff    <= '0;
         post_skip_ff   <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CsrHeaderSkip: header_skip_ff <= csr_wdata;
            CsrPreSkip:    pre_skip_ff    <= csr_wdata;
            CsrPostSkip:   post_skip_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Per-byte state update
   always_comb begin
      phase_in       = phase_ff;
      skip_count_in  = skip_count_ff;
      remaining_in   = remaining_ff;
      length_high_in = length_high_ff;
      pos_in         = pos_ff;
      area_in        = area_ff;
      ident_in       = ident_ff;
      pair_valid_in  = pair_valid_ff;
      body_done_in   = body_done_ff;
      emit           = 1'b0;
      rsp_area_in    = '0;
      rsp_ident_in   = '0;
      rsp_status_in  = StatusPairFound;

      if (accept) begin
         unique case (phase_ff)
            PH_HEADER, PH_POST: begin
               if ((phase_ff == PH_HEADER && skip_count_ff < header_skip_ff) ||
                   (phase_ff == PH_POST && skip_count_ff < post_skip_ff)) begin
                  skip_count_in = skip_count_ff + 16'd1;
               end else if (pre_skip_ff != '0) begin
                  // byte is the first of the pre-block skip
                  phase_in      = PH_PRE;
                  skip_count_in = 16'd1;
               end else begin
                  // no pre skip: byte is the category
                  phase_in      = PH_LEN_HI;
                  skip_count_in = '0;
               end
            end
            PH_PRE: begin
               if (skip_count_ff < pre_skip_ff) begin
                  skip_count_in = skip_count_ff + 16'd1;
               end else begin
                  phase_in      = PH_LEN_HI;
                  skip_count_in = '0;
               end
            end
            PH_CAT: begin
               phase_in = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               length_high_in = b;
               phase_in       = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (length < MinBlockLength) begin
                  phase_in      = PH_HALT;
                  emit          = 1'b1;
                  rsp_status_in = StatusBadLength;
               end else begin
                  remaining_in  = length - MinBlockLength;
                  pos_in        = POS_FIRST;
                  pair_valid_in = 1'b0;
                  body_done_in  = 1'b0;
                  if (length == MinBlockLength) begin
                     // empty body ends the block here, nothing captured
                     phase_in      = PH_POST;
                     skip_count_in = '0;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (!body_done_ff) begin
                  case (pos_ff)
                     POS_FIRST: begin
                        if (b[FspecSacSicBit])
                           pos_in = b[FspecExtBit] ? POS_EXT : POS_SAC;
                        else
                           body_done_in = 1'b1;
                     end
                     POS_EXT: begin
                        if (!b[FspecExtBit]) pos_in = POS_SAC;
                     end
                     POS_SAC: begin
                        area_in = b;
                        pos_in  = POS_SIC;
                     end
                     default: begin
                        ident_in      = b;
                        pair_valid_in = 1'b1;
                        body_done_in  = 1'b1;
                     end
                  endcase
               end
               remaining_in = remaining_ff - 16'd1;
               if (remaining_ff == 16'd1) begin
                  phase_in      = PH_POST;
                  skip_count_in = '0;
                  emit          = pair_valid_in;
                  rsp_area_in   = area_in;
                  rsp_ident_in  = ident_in;
               end
            end
            PH_HALT: ;
            default: phase_in = PH_HALT;
         endcase
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         skip_count_ff  <= '0;
         remaining_ff   <= '0;
         length_high_ff <= '0;
         pos_ff         <= POS_FIRST;
         area_ff        <= '0;
         ident_ff       <= '0;
         pair_valid_ff  <= 1'b0;
         body_done_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         skip_count_ff  <= skip_count_in;
         remaining_ff   <= remaining_in;
         length_high_ff <= length_high_in;
         pos_ff         <= pos_in;
         area_ff        <= area_in;
         ident_ff       <= ident_in;
         pair_valid_ff  <= pair_valid_in;
         body_done_ff   <= body_done_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload loads only with a new transfer
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_area_ff   <= rsp_area_in;
         rsp_ident_ff  <= rsp_ident_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspTdataWidth - RspFieldWidth){1'b0}},
                        rsp_status_ff, rsp_ident_ff, rsp_area_ff};

endmodule
